// ===== rtl/core/pasf_pkg.sv =====
`default_nettype none
package pasf_pkg;

  localparam int COORD_BITS_DEF = 24;

  // configuration port
  localparam int MSL_W      = 23;
  localparam int COS_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEG_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_MIN_TURN = 1'd1;

  localparam logic [MSL_W-1:0] MSL_RST = 23'd100;
  localparam logic [COS_W-1:0] COS_RST = 16'd32276;

  // Q1.15 squared: scale of the dot product side of the cosine compare
  localparam int COS_SH = 2 * (COS_W - 1);

  // multiplier loop indexes
  localparam int LO_W = 3;
  localparam int HI_W = 2;

  // product kinds in the squares phase (carried in the hi index)
  localparam logic [HI_W-1:0] SQ_UU = 2'd0;
  localparam logic [HI_W-1:0] SQ_VV = 2'd1;
  localparam logic [HI_W-1:0] SQ_UV = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_DRAIN,
    S_DOT,
    S_CHECK,
    S_LOAD,
    S_DECIDE,
    S_EMITH,
    S_TAIL,
    S_EMITF
  } ctrl_state_t;

  typedef enum logic [2:0] {
    PH_SQ,
    PH_DD,
    PH_NN,
    PH_C1,
    PH_C2
  } phase_t;

  typedef enum logic [2:0] {
    DOP_NONE,
    DOP_DIFF,
    DOP_MUL_SQ,
    DOP_MUL_AB,
    DOP_DOT,
    DOP_LD_DD,
    DOP_LD_NN,
    DOP_LD_C
  } dp_op_t;

  typedef enum logic [2:0] {
    T_NONE,
    T_NU,
    T_NV,
    T_DP,
    T_DN,
    T_ACC
  } acc_tgt_t;

  typedef struct packed {
    dp_op_t          op;
    logic [LO_W-1:0] lo;
    logic [HI_W-1:0] hi;
    logic            capture;
    logic            out_load;
    logic            out_sel_held;
    logic            out_eop;
    logic            keep_new;
    logic            keep_held;
    logic            hold_new;
  } dp_cmd_t;

  typedef struct packed {
    logic near_kept;
    logic nu_zero;
    logic nv_zero;
    logic dneg;
    logic cneg;
    logic lhs_gt;
    logic lhs_lt;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pasf_if.sv =====
`default_nettype none
interface pasf_in_if import pasf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;
  logic                         final_point;

  modport source (output valid, px, py, pz, final_point, input ready);
  modport sink   (input valid, px, py, pz, final_point, output ready);
endinterface

interface pasf_out_if import pasf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] kx;
  logic signed [COORD_BITS-1:0] ky;
  logic signed [COORD_BITS-1:0] kz;
  logic                         end_of_path;

  modport source (output valid, kx, ky, kz, end_of_path, input ready);
  modport sink   (input valid, kx, ky, kz, end_of_path, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pasf_ctrl.sv =====
`default_nettype none
module pasf_ctrl import pasf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_final,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  ctrl_state_t     state_r, state_nxt;
  phase_t          ph_r, ph_nxt;
  logic [LO_W-1:0] lo_r, lo_nxt, lo_last;
  logic [HI_W-1:0] hi_r, hi_nxt, hi_last;
  logic            in_path_r, in_path_nxt;
  logic            held_vld_r, held_vld_nxt;
  logic            fin_r, fin_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            tiny;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign tiny      = st.dneg ? st.lhs_lt : st.lhs_gt;

  // loop bounds per multiply phase, limbs of the operand registers
  always_comb begin
    unique case (ph_r)
      PH_SQ:   begin lo_last = 3'd2; hi_last = 2'd2; end
      PH_DD:   begin lo_last = 3'd1; hi_last = 2'd1; end
      PH_NN:   begin lo_last = 3'd1; hi_last = 2'd1; end
      PH_C1:   begin lo_last = 3'd3; hi_last = 2'd0; end
      PH_C2:   begin lo_last = 3'd4; hi_last = 2'd0; end
      default: begin lo_last = 3'd0; hi_last = 2'd0; end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    ph_nxt       = ph_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    in_path_nxt  = in_path_r;
    held_vld_nxt = held_vld_r;
    fin_nxt      = fin_r;
    cmd          = '0;
    cmd.op       = DOP_NONE;
    cmd.lo       = lo_r;
    cmd.hi       = hi_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          fin_nxt     = in_final;
          priority if (!in_path_r) state_nxt = S_EMITF;
          else if (held_vld_r)     state_nxt = S_DIFF;
          else                     state_nxt = S_TAIL;
        end
      end
      S_DIFF: begin
        cmd.op    = DOP_DIFF;
        ph_nxt    = PH_SQ;
        lo_nxt    = '0;
        hi_nxt    = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = (ph_r == PH_SQ) ? DOP_MUL_SQ : DOP_MUL_AB;
        if (lo_r == lo_last) begin
          lo_nxt = '0;
          if (hi_r == hi_last) begin
            hi_nxt    = '0;
            state_nxt = S_DRAIN;
          end else begin
            hi_nxt = hi_r + 2'd1;
          end
        end else begin
          lo_nxt = lo_r + 3'd1;
        end
      end
      S_DRAIN: begin
        // last product lands in its accumulator during this cycle
        unique case (ph_r)
          PH_SQ:   state_nxt = S_DOT;
          PH_DD:   begin ph_nxt = PH_NN; state_nxt = S_LOAD; end
          PH_NN:   begin ph_nxt = PH_C1; state_nxt = S_LOAD; end
          PH_C1:   begin ph_nxt = PH_C2; state_nxt = S_LOAD; end
          PH_C2:   state_nxt = S_DECIDE;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DOT: begin
        cmd.op    = DOP_DOT;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (!st.near_kept)           state_nxt = S_EMITH;
        else if (st.nu_zero || st.nv_zero)    state_nxt = S_TAIL;
        else if (!st.dneg && st.cneg)         state_nxt = S_TAIL;
        else if (st.dneg && !st.cneg)         state_nxt = S_EMITH;
        else begin
          ph_nxt    = PH_DD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        unique case (ph_r)
          PH_DD:        cmd.op = DOP_LD_DD;
          PH_NN:        cmd.op = DOP_LD_NN;
          PH_C1, PH_C2: cmd.op = DOP_LD_C;
          default:      cmd.op = DOP_NONE;
        endcase
        lo_nxt    = '0;
        hi_nxt    = '0;
        state_nxt = S_MUL;
      end
      S_DECIDE: begin
        state_nxt = tiny ? S_TAIL : S_EMITH;
      end
      S_EMITH: begin
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_held = 1'b1;
          cmd.keep_held    = 1'b1;
          state_nxt        = S_TAIL;
        end
      end
      S_TAIL: begin
        if (fin_r) begin
          state_nxt = S_EMITF;
        end else begin
          cmd.hold_new = 1'b1;
          held_vld_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMITF: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_eop  = fin_r;
          if (in_path_r) begin
            in_path_nxt  = 1'b0;
            held_vld_nxt = 1'b0;
          end else if (!fin_r) begin
            // first point of a longer path
            in_path_nxt  = 1'b1;
            held_vld_nxt = 1'b0;
            cmd.keep_new = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_SQ;
      lo_r        <= '0;
      hi_r        <= '0;
      in_path_r   <= 1'b0;
      held_vld_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      in_path_r   <= in_path_nxt;
      held_vld_r  <= held_vld_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pasf_dp.sv =====
`default_nettype none
module pasf_dp import pasf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  output logic signed [COORD_BITS-1:0] out_kx,
  output logic signed [COORD_BITS-1:0] out_ky,
  output logic signed [COORD_BITS-1:0] out_kz,
  output logic                         out_eop,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     st
);

  // difference magnitude, limb width, and widths of the sums and products
  localparam int D   = COORD_BITS + 1;
  localparam int LW  = (D > COS_W) ? D : COS_W;
  localparam int NW  = 2 * LW;
  localparam int AL  = 5;
  localparam int BL  = 2;
  localparam int ACW = 6 * LW;
  localparam int SEW = (NW > 2 * MSL_W) ? NW : 2 * MSL_W;

  logic [MSL_W-1:0]        msl_r;
  logic [COS_W-1:0]        cos_r;
  logic [2*MSL_W-1:0]      msl_sq_r;
  logic [COS_W-1:0]        cmag;

  logic [COORD_BITS-1:0]   n_r [3];
  logic [COORD_BITS-1:0]   h_r [3];
  logic [COORD_BITS-1:0]   k_r [3];
  logic [COORD_BITS-1:0]   ko_r [3];
  logic                    eop_r;

  logic [D-1:0]            mu_r [3];
  logic [D-1:0]            mv_r [3];
  logic                    su_r [3];
  logic                    sv_r [3];

  logic [NW-1:0]           nu_r, nv_r, dp_r, dn_r, dmag_r;
  logic                    dneg_r, se_r, nuz_r, nvz_r;

  logic [LW-1:0]           a_r [AL];
  logic [LW-1:0]           b_r [BL];
  logic [ACW-1:0]          acc_r;
  logic [4*LW-1:0]         lhs_r;
  logic [ACW-1:0]          lhs_sh;

  logic [NW-1:0]           pp_r;
  acc_tgt_t                tgt_r, tgt;
  logic [LO_W-1:0]         pos_r;
  logic [LW-1:0]           mul_a, mul_b;
  logic [1:0]              ax;
  logic [D-1:0]            mu_sel, mv_sel;
  logic                    uv_neg;
  logic                    ld_any;

  function automatic logic [D:0] diff_sm(input logic [COORD_BITS-1:0] a,
                                         input logic [COORD_BITS-1:0] b);
    logic [D-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return {d[D-1], d[D-1] ? (~d + 1'b1) : d};
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msl_r <= MSL_RST;
      cos_r <= COS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MIN_SEG_LEN:  msl_r <= cfg_data[MSL_W-1:0];
        CFG_COS_MIN_TURN: cos_r <= cfg_data[COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    msl_sq_r <= msl_r * msl_r;
  end

  assign cmag = cos_r[COS_W-1] ? (~cos_r + 1'b1) : cos_r;

  // points and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r[0] <= in_px;
      n_r[1] <= in_py;
      n_r[2] <= in_pz;
    end
    if (cmd.keep_new)       k_r <= n_r;
    else if (cmd.keep_held) k_r <= h_r;
    if (cmd.hold_new) h_r <= n_r;
    if (cmd.out_load) begin
      for (int i = 0; i < 3; i++) ko_r[i] <= cmd.out_sel_held ? h_r[i] : n_r[i];
      eop_r <= cmd.out_eop;
    end
  end

  assign out_kx  = ko_r[0];
  assign out_ky  = ko_r[1];
  assign out_kz  = ko_r[2];
  assign out_eop = eop_r;

  // u = held - kept, v = next - held, as sign and magnitude
  always_ff @(posedge clk) begin
    if (cmd.op == DOP_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        {su_r[i], mu_r[i]} <= diff_sm(h_r[i], k_r[i]);
        {sv_r[i], mv_r[i]} <= diff_sm(n_r[i], h_r[i]);
      end
    end
  end

  // shared multiplier operand select
  assign ax     = cmd.lo[1:0];
  assign mu_sel = mu_r[ax];
  assign mv_sel = mv_r[ax];
  assign uv_neg = su_r[ax] ^ sv_r[ax];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tgt   = T_NONE;
    unique case (cmd.op)
      DOP_MUL_SQ: begin
        mul_a = LW'((cmd.hi == SQ_VV) ? mv_sel : mu_sel);
        mul_b = LW'((cmd.hi == SQ_UU) ? mu_sel : mv_sel);
        priority if (cmd.hi == SQ_UU) tgt = T_NU;
        else if (cmd.hi == SQ_VV)     tgt = T_NV;
        else                          tgt = uv_neg ? T_DN : T_DP;
      end
      DOP_MUL_AB: begin
        mul_a = a_r[cmd.lo];
        mul_b = b_r[cmd.hi[0]];
        tgt   = T_ACC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pp_r  <= mul_a * mul_b;
    pos_r <= cmd.lo + {{(LO_W-1){1'b0}}, cmd.hi[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tgt_r <= T_NONE;
    else        tgt_r <= tgt;
  end

  // accumulators for the three sums of products
  always_ff @(posedge clk) begin
    if (cmd.op == DOP_DIFF) begin
      nu_r <= '0;
      nv_r <= '0;
      dp_r <= '0;
      dn_r <= '0;
    end else begin
      unique case (tgt_r)
        T_NU:    nu_r <= nu_r + pp_r;
        T_NV:    nv_r <= nv_r + pp_r;
        T_DP:    dp_r <= dp_r + pp_r;
        T_DN:    dn_r <= dn_r + pp_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DOP_DOT) begin
      dneg_r <= dn_r > dp_r;
      dmag_r <= (dn_r > dp_r) ? (dn_r - dp_r) : (dp_r - dn_r);
      se_r   <= SEW'(nu_r) < SEW'(msl_sq_r);
      nuz_r  <= (nu_r == '0);
      nvz_r  <= (nv_r == '0);
    end
  end

  // multi-limb products: lhs = dot^2, rhs = nu * nv * c * c
  assign ld_any = (cmd.op == DOP_LD_DD) || (cmd.op == DOP_LD_NN) || (cmd.op == DOP_LD_C);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DOP_LD_DD: begin
        for (int i = 2; i < AL; i++) a_r[i] <= '0;
        a_r[0] <= dmag_r[LW-1:0];
        a_r[1] <= dmag_r[NW-1:LW];
        b_r[0] <= dmag_r[LW-1:0];
        b_r[1] <= dmag_r[NW-1:LW];
      end
      DOP_LD_NN: begin
        for (int i = 2; i < AL; i++) a_r[i] <= '0;
        a_r[0] <= nu_r[LW-1:0];
        a_r[1] <= nu_r[NW-1:LW];
        b_r[0] <= nv_r[LW-1:0];
        b_r[1] <= nv_r[NW-1:LW];
        lhs_r  <= acc_r[4*LW-1:0];
      end
      DOP_LD_C: begin
        for (int i = 0; i < AL; i++) a_r[i] <= acc_r[i*LW +: LW];
        b_r[0] <= LW'(cmag);
        b_r[1] <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_any)              acc_r <= '0;
    else if (tgt_r == T_ACC) acc_r <= acc_r + (ACW'(pp_r) << (LW * pos_r));
  end

  assign lhs_sh = {{(ACW-4*LW-COS_SH){1'b0}}, lhs_r, {COS_SH{1'b0}}};

  assign st.near_kept  = se_r;
  assign st.nu_zero    = nuz_r;
  assign st.nv_zero    = nvz_r;
  assign st.dneg       = dneg_r;
  assign st.cneg       = cos_r[COS_W-1];
  assign st.lhs_gt     = lhs_sh > acc_r;
  assign st.lhs_lt     = lhs_sh < acc_r;

endmodule
`default_nettype wire

// ===== rtl/core/polyline_angle_spacing_filter.sv =====
`default_nettype none
// Path waypoint thinning. Waypoints enter on in_ch (valid/ready), one item
// per point, final_point set on the last point of a path. Kept waypoints
// leave on out_ch, end_of_path set on the last one. cfg_we/cfg_idx/cfg_data
// write the minimum segment length (index 0) and the turn cosine threshold
// (index 1); write them only while the block is idle.
// One item is in work at a time. The first point of a path is emitted at
// once; a point with nothing held is held, or emitted if it ends the path.
// A held point is decided by distance, a zero vector or the signs of dot and
// cosine, or else by the full cosine compare. The rate is set by the
// single shared multiplier: 9 products for the sums of squares and dot, then
// 17 limb products for the squared cosine compare.
// A result waits in an output register; while it waits the block still takes
// the next item and works on it, stalling only when it must load a second
// result. Reset empties the output register, forgets any open path and
// restores the register defaults (100 mm, cos 32276/32768).
module polyline_angle_spacing_filter import pasf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pasf_in_if.sink               in_ch,
  pasf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  pasf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_final  (in_ch.final_point),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  pasf_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_px    (in_ch.px),
    .in_py    (in_ch.py),
    .in_pz    (in_ch.pz),
    .out_kx   (out_ch.kx),
    .out_ky   (out_ch.ky),
    .out_kz   (out_ch.kz),
    .out_eop  (out_ch.end_of_path),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pasf_checker.sv =====
`default_nettype none
module pasf_checker import pasf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_final,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_kx,
  input logic [COORD_BITS-1:0] out_ky,
  input logic [COORD_BITS-1:0] out_kz,
  input logic                  out_eop
);

  // final points taken whose end_of_path item has not left yet
  logic [1:0] fin_cnt_r, fin_cnt_nxt;
  logic       fin_in, eop_out;

  assign fin_in  = in_valid && in_ready && in_final;
  assign eop_out = out_valid && out_ready && out_eop;

  always_comb begin
    fin_cnt_nxt = fin_cnt_r;
    if (fin_in && !eop_out)      fin_cnt_nxt = fin_cnt_r + 2'd1;
    else if (!fin_in && eop_out) fin_cnt_nxt = fin_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_cnt_r <= '0;
    else        fin_cnt_r <= fin_cnt_nxt;
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kx) && $stable(out_ky)
      && $stable(out_kz) && $stable(out_eop))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_eop_match: assert property (@(posedge clk) disable iff (!rst_n)
    eop_out |-> fin_cnt_r != 2'd0)
    else $error("end_of_path without a final point");

  a_eop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r != 2'd3)
    else $error("too many paths ended without end_of_path");

endmodule

bind polyline_angle_spacing_filter pasf_checker #(
  .COORD_BITS (COORD_BITS)
) u_pasf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_point),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kx    (out_ch.kx),
  .out_ky    (out_ch.ky),
  .out_kz    (out_ch.kz),
  .out_eop   (out_ch.end_of_path)
);
`default_nettype wire
